>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the Sobel edge magnitude unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Types and constants shared by the Sobel edge magnitude controller,
// datapath and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sem_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 4096;

  localparam int PIX_W      = 8;
  localparam int CFG_WID_W  = 12;
  localparam int CFG_HGT_W  = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int ROW_W      = 13;
  localparam int OROW_W     = 12;
  localparam int CMP_W      = 14;
  localparam int ABS_W      = 10;
  localparam int PROD_W     = 20;
  localparam int SUM_W      = 21;
  localparam int ROOT_W     = 8;
  localparam int REM_W      = 10;
  localparam int STEP_W     = 3;

  localparam logic [CFG_WID_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_HGT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [PIX_W-1:0]     SAT_MAG      = 8'd255;
  localparam logic [STEP_W-1:0]    ROOT_LAST    = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Input kinds carried on tuser.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic accept;       // capture the input word and read the line store
    logic window_step;  // shift the window, write the line store, move counters
    logic square_v;     // square the vertical gradient
    logic square_h;     // add the square of the horizontal gradient
    logic root_step;    // one digit of the square root
    logic load_out;     // move the result into the output register
  } sem_cmd_t;

  typedef struct packed {
    logic emit;         // the current item produces a result
    logic out_busy;     // output register holds a word that is not taken
  } sem_status_t;

endpackage

>>> rtl/sem_ctrl.sv
// ----------------------------------------------------------------------------
// sem_ctrl
// Sequencer for one input word: accept, window update and, if it yields a result,
// two multiply steps, eight square root steps and the output hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sem_ctrl
  import sem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  sem_status_t status,
  output sem_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_WIN  = 6'b000010,
    ST_SQV  = 6'b000100,
    ST_SQH  = 6'b001000,
    ST_ROOT = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_WIN;
        end
      end
      ST_WIN: begin
        cmd.window_step = 1'b1;
        state_nxt = status.emit ? ST_SQV : ST_IDLE;
      end
      ST_SQV: begin
        cmd.square_v = 1'b1;
        state_nxt    = ST_SQH;
      end
      ST_SQH: begin
        cmd.square_h = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        step_nxt      = step_r + STEP_W'(1);
        if (step_r == ROOT_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Wait until the previous result has left the output register.
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  `SEM_ASSERT_NEXT(a_accept_to_win, clk, rst_n, accept, state_r == ST_WIN, "accept did not start the window step")
  `SEM_ASSERT_NEXT(a_root_done, clk, rst_n, (state_r == ST_ROOT) && (step_r == ROOT_LAST), state_r == ST_FIN, "root did not end after eight steps")
  `SEM_ASSERT_NEXT(a_silent_item, clk, rst_n, (state_r == ST_WIN) && !status.emit, state_r == ST_IDLE, "item without result did not return to idle")

endmodule

>>> rtl/sem_datapath.sv
// ----------------------------------------------------------------------------
// sem_datapath
// Configuration registers, line store, 3x3 window, position counters,
// gradient squares, digit-by-digit square root and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sem_datapath
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tuser,
  input  logic [PIX_W-1:0]      in_tdata,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [PIX_W-1:0]      out_tdata,
  output logic                  out_tlast,
  input  sem_cmd_t              cmd,
  output sem_status_t           status
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CFG_WID_W-1:0]  width_r;
  logic [CFG_HGT_W-1:0]  height_r;
  logic [CFG_WID_W-1:0]  eff_w;
  logic [CFG_HGT_W-1:0]  eff_h;

  logic [CW-1:0]         col_r, ocol_r;
  logic [ROW_W-1:0]      irow_r;
  logic [OROW_W-1:0]     orow_r;

  // Each entry holds {upper row, middle row} for one column.
  logic [2*PIX_W-1:0]    line_mem [0:MAX_WIDTH-1];
  logic [2*PIX_W-1:0]    mem_rd_r;

  logic                  cmd_r;
  logic [PIX_W-1:0]      pix_r;
  logic [PIX_W-1:0]      win_r   [0:8];
  logic [PIX_W-1:0]      win_nxt [0:8];
  logic [PIX_W-1:0]      calc    [0:8];

  logic [PIX_W-1:0]      v, top, mid;
  logic                  col0, emit, last, col_wrap, restart;
  logic signed [11:0]    s [0:8];
  logic signed [11:0]    gv, gh, gv_abs, gh_abs;

  logic [ABS_W-1:0]      av_r, ah_r, mul_a;
  logic [PROD_W-1:0]     mul, prod_r;
  logic [SUM_W-1:0]      sum;
  logic                  sat_r, last_r;
  logic [2*ROOT_W-1:0]   n_r;
  logic [REM_W-1:0]      rem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [REM_W+1:0]      cand, trial;

  logic                  out_valid_r;
  logic [PIX_W-1:0]      out_data_r;
  logic                  out_last_r;

  // Out-of-range register values fall back to the nearest legal size.
  always_comb begin
    if (width_r == '0) begin
      eff_w = CFG_WID_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = CFG_WID_W'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    if (height_r == '0) begin
      eff_h = CFG_HGT_W'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      eff_h = CFG_HGT_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  // Window update and neighborhood for the current item.
  always_comb begin
    v   = ((cmd_r == CMD_PIXEL) && (irow_r < eff_h)) ? pix_r : '0;
    top = ((irow_r >= ROW_W'(2)) && ((irow_r - ROW_W'(2)) < eff_h)) ?
          mem_rd_r[2*PIX_W-1:PIX_W] : '0;
    mid = ((irow_r >= ROW_W'(1)) && ((irow_r - ROW_W'(1)) < eff_h)) ?
          mem_rd_r[PIX_W-1:0] : '0;
    col0 = (col_r == '0);
    for (int k = 0; k < 3; k++) begin
      if (col0) begin
        // The previous row's last pixel is finished with a zero right column.
        calc[k*3]      = win_r[k*3+1];
        calc[k*3+1]    = win_r[k*3+2];
        calc[k*3+2]    = '0;
        win_nxt[k*3]   = '0;
        win_nxt[k*3+1] = '0;
      end else begin
        calc[k*3]      = '0;
        calc[k*3+1]    = '0;
        calc[k*3+2]    = '0;
        win_nxt[k*3]   = win_r[k*3+1];
        win_nxt[k*3+1] = win_r[k*3+2];
      end
    end
    win_nxt[2] = top;
    win_nxt[5] = mid;
    win_nxt[8] = v;
    if (!col0) begin
      for (int i = 0; i < 9; i++) begin
        calc[i] = win_nxt[i];
      end
    end
    for (int i = 0; i < 9; i++) begin
      s[i] = signed'({4'd0, calc[i]});
    end
    gv = s[6] + (s[7] <<< 1) + s[8] - s[0] - (s[1] <<< 1) - s[2];
    gh = s[2] + (s[5] <<< 1) + s[8] - s[0] - (s[3] <<< 1) - s[6];
    gv_abs = gv[11] ? -gv : gv;
    gh_abs = gh[11] ? -gh : gh;
  end

  assign emit     = (irow_r >= ROW_W'(2)) || ((irow_r == ROW_W'(1)) && !col0);
  assign last     = ((CMP_W'(orow_r) + CMP_W'(1)) >= CMP_W'(eff_h)) &&
                    ((CMP_W'(ocol_r) + CMP_W'(1)) >= CMP_W'(eff_w));
  assign col_wrap = (CMP_W'(col_r) + CMP_W'(1)) >= CMP_W'(eff_w);
  assign restart  = emit && last;

  // One shared multiplier squares both gradients.
  assign mul_a = cmd.square_h ? ah_r : av_r;
  assign mul   = PROD_W'(mul_a) * PROD_W'(mul_a);
  assign sum   = SUM_W'(prod_r) + SUM_W'(mul);

  // Restoring square root, two radicand bits per step.
  assign cand  = {rem_r, n_r[2*ROOT_W-1:2*ROOT_W-2]};
  assign trial = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      col_r    <= '0;
      irow_r   <= '0;
      ocol_r   <= '0;
      orow_r   <= '0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[CFG_WID_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[CFG_HGT_W-1:0];
        default: ;
      endcase
      // Any register write starts a new image.
      col_r  <= '0;
      irow_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.window_step) begin
      if (restart) begin
        col_r  <= '0;
        irow_r <= '0;
        ocol_r <= '0;
        orow_r <= '0;
        for (int i = 0; i < 9; i++) begin
          win_r[i] <= '0;
        end
      end else begin
        for (int i = 0; i < 9; i++) begin
          win_r[i] <= win_nxt[i];
        end
        if (col_wrap) begin
          col_r  <= '0;
          irow_r <= irow_r + ROW_W'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
        if (emit) begin
          if ((CMP_W'(ocol_r) + CMP_W'(1)) >= CMP_W'(eff_w)) begin
            ocol_r <= '0;
            orow_r <= orow_r + OROW_W'(1);
          end else begin
            ocol_r <= ocol_r + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r    <= in_tuser;
      pix_r    <= in_tdata;
      mem_rd_r <= line_mem[col_r];
    end
    if (cmd.window_step) begin
      line_mem[col_r] <= {mem_rd_r[PIX_W-1:0], v};
      av_r   <= gv_abs[ABS_W-1:0];
      ah_r   <= gh_abs[ABS_W-1:0];
      last_r <= restart;
    end
    if (cmd.square_v) begin
      prod_r <= mul;
    end
    if (cmd.square_h) begin
      sat_r  <= |sum[SUM_W-1:2*ROOT_W];
      n_r    <= sum[2*ROOT_W-1:0];
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.root_step) begin
      n_r <= {n_r[2*ROOT_W-3:0], 2'b00};
      if (cand >= trial) begin
        rem_r  <= REM_W'(cand - trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= REM_W'(cand);
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      out_data_r <= sat_r ? SAT_MAG : root_r;
      out_last_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;
  assign out_tlast       = out_last_r;
  assign status.emit     = emit;
  assign status.out_busy = out_valid_r && !out_tready;

  `SEM_ASSERT_NEXT(a_cfg_restart, clk, rst_n, cfg_we, (col_r == '0) && (irow_r == '0),
                   "register write did not restart the image")
  `SEM_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.load_out, !out_valid_r || out_tready,
                  "result overwrote a word not yet taken")
  `SEM_ASSERT_NOW(a_col_range, clk, rst_n, 1'b1, CMP_W'(col_r) < CMP_W'(eff_w),
                  "input column ran past the row")

endmodule

>>> rtl/sobel_edge_magnitude_unit.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_unit
// Streams an 8-bit greyscale image in raster order (tuser low = pixel,
// tuser high = drain word) and returns floor(sqrt(Gx^2 + Gy^2)) of the 3x3
// Sobel gradients, saturated at 255, with neighbors outside the image taken
// as zero. Results lag the input by width+1 words, so width+1 drain words
// follow the last pixel; tlast marks the final pixel of the image. A word
// that yields a result goes through accept, window update, two passes
// through one shared multiplier, eight square root steps and the output
// hand-off, held while the output register is busy; other words take only
// accept and window update. A new word enters once the last is done; the
// output register lets it enter while a result waits. A write to either
// size register restarts the image. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_edge_magnitude_unit
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // [7:0] pixel_value
  input  logic                  in_tuser,   // [0] cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_tdata,  // [7:0] magnitude
  output logic                  out_tlast
);

  sem_cmd_t    cmd;
  sem_status_t status;

  sem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  sem_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
